FILE: rtl/lfot_pkg.sv
// Shared types and constants for the LED frame output treatment block.
// Pixel and result payloads, the queued work item, register codes and fixed tables.
// Used by every module under rtl/.
`timescale 1ns / 1ps

package lfot_pkg;

	// Configuration register indexes
	localparam logic [2:0] CFG_MODE_FLAGS     = 3'd0;
	localparam logic [2:0] CFG_TINT_AMT       = 3'd1;
	localparam logic [2:0] CFG_COVER_OPA      = 3'd2;
	localparam logic [2:0] CFG_BASE_INTENSITY = 3'd3;
	localparam logic [2:0] CFG_RING_NUM       = 3'd4;

	// Bits of mode_flags
	localparam int FLAG_INCAND    = 0;
	localparam int FLAG_CLEAN     = 1;
	localparam int FLAG_BASE      = 2;
	localparam int FLAG_PRISM_OFF = 3;
	localparam int FLAG_REVERSE   = 4;
	localparam int FLAG_DITHER    = 5;

	localparam int LANE_R = 0;
	localparam int LANE_G = 1;
	localparam int LANE_B = 2;
	localparam int LANES  = 3;

	localparam int PRISM_MAX = 8;
	localparam int QDEPTH    = 2;

	localparam logic [14:0] ONE_Q14 = 15'd16384;

	// Amber tint per lane, U2.14
	localparam logic [14:0] TINT [LANES] = '{15'd16384, 15'd7296, 15'd2559};
	// One minus tint: the mix factor is 2^28 - mix * slope
	localparam logic [14:0] SLOPE [LANES] = '{15'd0, 15'd9088, 15'd13825};

	typedef struct packed {
		logic [15:0] red_in;
		logic [15:0] green_in;
		logic [15:0] blue_in;
	} pix_in_t;

	typedef struct packed {
		logic [15:0] red_out;
		logic [15:0] green_out;
		logic [15:0] blue_out;
		logic [6:0]  position;
		logic        frame_end;
		logic [1:0]  phase_out;
	} pix_out_t;

	typedef struct packed {
		logic [5:0]  mode_flags;
		logic [14:0] tint_amt;
		logic [14:0] cover_opa;
		logic [14:0] base_intensity;
		logic [3:0]  ring_num;
	} cfg_regs_t;

	// One classified pixel waiting for the arithmetic back end
	typedef struct packed {
		logic [LANES-1:0][15:0] color;
		logic                   incand;
		logic                   mix_on;
		logic [14:0]            mix;
		logic                   cover_on;
		logic [16:0]            cover_scale;
		logic [10:0]            base_offset;
		logic [LANES-1:0][11:0] floor_lvl;
		logic [6:0]             position;
		logic                   frame_end;
		logic [1:0]             phase;
	} work_t;

	function automatic logic [14:0] sat_one(input logic [14:0] v);
		return (v > ONE_Q14) ? ONE_Q14 : v;
	endfunction

	// round(gain * 16384 / 255) with gain = 48 - 4p
	function automatic logic [11:0] prism_full(input logic [2:0] p);
		logic [11:0] v;
		case (p)
			3'd0: v = 12'd3084;
			3'd1: v = 12'd2827;
			3'd2: v = 12'd2570;
			3'd3: v = 12'd2313;
			3'd4: v = 12'd2056;
			3'd5: v = 12'd1799;
			3'd6: v = 12'd1542;
			3'd7: v = 12'd1285;
			default: v = 12'd0;
		endcase
		return v;
	endfunction

	// round(floor(gain / 2) * 16384 / 255)
	function automatic logic [11:0] prism_half(input logic [2:0] p);
		logic [11:0] v;
		case (p)
			3'd0: v = 12'd1542;
			3'd1: v = 12'd1414;
			3'd2: v = 12'd1285;
			3'd3: v = 12'd1157;
			3'd4: v = 12'd1028;
			3'd5: v = 12'd900;
			3'd6: v = 12'd771;
			3'd7: v = 12'd643;
			default: v = 12'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/led_frame_output_treatment_top.sv
// LED frame output treatment: pixel input, configuration port, treated pixel output.
// Holds the configuration registers and joins front, queue and back. Depends on lfot_pkg.
//
// Usage:
//   Pixels enter on in_valid / in_stall with in_data (U2.14 red, green, blue) in
//   strip order; a transaction completes when in_valid is high and in_stall low.
//   Each pixel yields one result on out_valid / out_stall: the treated color,
//   display position, a frame_end mark on the last pixel and the dither phase.
//   Registers are written through cfg_valid / cfg_ready with cfg_index and
//   cfg_data; cfg_ready is always high. Write them only while no pixel is in flight.
//   The back end steps one multiplier per lane through color, cover and a final
//   output step, and takes no new pixel from the queue until it finishes the current one.
//   A two-entry queue sits between the front and the back end; in_stall rises
//   when it is full. When the receiver stalls, the result holds in the output
//   register and the back end waits at its final step until the register frees.
//   Reset clears the registers, the frame position and the dither phase, and
//   empties the queue and the output register.
`timescale 1ns / 1ps

module led_frame_output_treatment_top
	import lfot_pkg::*;
#(
	parameter int PIXELS = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  pix_in_t     in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output pix_out_t    out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_regs_t cfg_q;
	logic      q_full;
	logic      q_empty;
	logic      push;
	logic      pop;
	work_t     push_data;
	work_t     head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MODE_FLAGS:     cfg_q.mode_flags     <= cfg_data[5:0];
				CFG_TINT_AMT:       cfg_q.tint_amt       <= cfg_data[14:0];
				CFG_COVER_OPA:      cfg_q.cover_opa      <= cfg_data[14:0];
				CFG_BASE_INTENSITY: cfg_q.base_intensity <= cfg_data[14:0];
				CFG_RING_NUM:       cfg_q.ring_num       <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	lfot_front #(
		.PIXELS(PIXELS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.cfg       (cfg_q),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	lfot_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	lfot_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

FILE: rtl/lfot_front.sv
// Front end: accepts pixels, keeps the frame position and dither phase, classifies.
// Produces one work_t per pixel for the queue. Depends on lfot_pkg.
`timescale 1ns / 1ps

module lfot_front
	import lfot_pkg::*;
#(
	parameter int PIXELS = 128
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  pix_in_t   in_data,
	input  cfg_regs_t cfg,
	input  logic      q_full,
	output logic      push,
	output work_t     push_data
);

	localparam int CW   = $clog2(PIXELS);
	localparam int PW   = (CW > 7) ? CW : 7;
	localparam int HALF = PIXELS / 2;

	logic [CW-1:0] idx_q;
	logic [1:0]    phase_q;
	logic          last;
	logic [1:0]    phase_nxt;
	logic          clean;
	logic [14:0]   mix_eff;
	logic [14:0]   opa;
	logic [16:0]   opa3;
	logic [16:0]   opa4;
	logic [16:0]   scale;
	logic [14:0]   int_sat;
	logic [19:0]   bx;
	logic [18:0]   by;
	logic [27:0]   bq_prod;
	logic [10:0]   bq0;
	logic [18:0]   brem;
	logic [10:0]   bofs;
	logic [3:0]    ring_cnt;
	logic [15:0]   peak;
	logic [CW-1:0] pos;
	logic [PW-1:0] pos_w;
	logic [LANES-1:0][11:0] floor_lvl;

	assign in_stall = q_full;
	assign push     = in_valid & ~q_full;

	assign last      = (idx_q == CW'(PIXELS - 1));
	assign phase_nxt = (last && cfg.mode_flags[FLAG_DITHER]) ? phase_q + 2'd1 : phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			phase_q <= '0;
		end else if (push) begin
			idx_q   <= last ? '0 : idx_q + CW'(1);
			phase_q <= phase_nxt;
		end
	end

	assign clean   = cfg.mode_flags[FLAG_CLEAN];
	assign mix_eff = clean ? 15'd0 : sat_one(cfg.tint_amt);

	// Cover weights 1/4, 1, 1/4, 0 by strip index mod 4
	assign opa  = sat_one(cfg.cover_opa);
	assign opa3 = 17'(opa) * 17'd3;
	assign opa4 = {opa, 2'b00};

	always_comb begin
		case (idx_q[1:0])
			2'd0, 2'd2: scale = 17'h10000 - opa3;
			2'd1:       scale = 17'h10000;
			default:    scale = 17'h10000 - opa4;
		endcase
	end

	// Base offset round(i * 40 / 510): reciprocal estimate, then one correction
	assign int_sat = sat_one(cfg.base_intensity);
	assign bx      = 20'(int_sat) * 20'd40 + 20'd255;
	assign by      = bx[19:1];
	assign bq_prod = 28'(by) * 28'd257;
	assign bq0     = bq_prod[26:16];
	assign brem    = by - 19'(bq0) * 19'd255;
	assign bofs    = (brem >= 19'd255) ? bq0 + 11'd1 : bq0;

	assign ring_cnt = (cfg.ring_num > 4'd8) ? 4'd8 : cfg.ring_num;

	always_comb begin
		floor_lvl = '0;
		if (!cfg.mode_flags[FLAG_PRISM_OFF]) begin
			for (int p = 0; p < PRISM_MAX; p++) begin
				if (p < int'(ring_cnt) && (2 + 3 * p) <= HALF - 1
						&& HALF + 2 + 3 * p < PIXELS) begin
					if (int'(idx_q) == HALF - 1 - (2 + 3 * p)) begin
						floor_lvl[LANE_R] = prism_full(3'(p));
						floor_lvl[LANE_B] = prism_half(3'(p));
					end
					if (int'(idx_q) == HALF + 2 + 3 * p) begin
						floor_lvl[LANE_G] = prism_full(3'(p));
						floor_lvl[LANE_B] = prism_half(3'(p));
					end
				end
			end
		end
	end

	always_comb begin
		peak = in_data.red_in;
		if (in_data.green_in > peak) peak = in_data.green_in;
		if (in_data.blue_in > peak) peak = in_data.blue_in;
	end

	assign pos   = cfg.mode_flags[FLAG_REVERSE] ? CW'(PIXELS - 1) - idx_q : idx_q;
	assign pos_w = PW'(pos);

	always_comb begin
		push_data.incand = cfg.mode_flags[FLAG_INCAND];
		if (cfg.mode_flags[FLAG_INCAND]) begin
			push_data.color[LANE_R] = peak;
			push_data.color[LANE_G] = peak;
			push_data.color[LANE_B] = peak;
		end else begin
			push_data.color[LANE_R] = in_data.red_in;
			push_data.color[LANE_G] = in_data.green_in;
			push_data.color[LANE_B] = in_data.blue_in;
		end
		push_data.mix_on      = ~cfg.mode_flags[FLAG_INCAND] && (mix_eff != 15'd0);
		push_data.mix         = mix_eff;
		push_data.cover_on    = (opa != 15'd0);
		push_data.cover_scale = scale;
		push_data.base_offset = (cfg.mode_flags[FLAG_BASE] && !clean) ? bofs : 11'd0;
		push_data.floor_lvl   = floor_lvl;
		push_data.position    = pos_w[6:0];
		push_data.frame_end   = last;
		push_data.phase       = phase_nxt;
	end

endmodule

FILE: rtl/lfot_queue.sv
// Two-entry queue of classified pixels between front and back end.
// Lets either side stall on its own. Depends on lfot_pkg.
`timescale 1ns / 1ps

module lfot_queue
	import lfot_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  work_t push_data,
	input  logic  pop,
	output work_t head,
	output logic  full,
	output logic  empty
);

	localparam int AW = $clog2(QDEPTH);

	work_t           mem_q [QDEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [AW:0]     count_q;

	assign full  = (count_q == (AW + 1)'(QDEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + AW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + AW'(1);
			if (push && !pop) count_q <= count_q + (AW + 1)'(1);
			else if (pop && !push) count_q <= count_q - (AW + 1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

FILE: rtl/lfot_back.sv
// Back end: three multiply lanes stepped through mix factor, color and cover,
// then base offset, prism floor, saturation and the output register. Depends on lfot_pkg.
`timescale 1ns / 1ps

module lfot_back
	import lfot_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  work_t    head,
	input  logic     empty,
	output logic     pop,
	output logic     out_valid,
	input  logic     out_stall,
	output pix_out_t out_data
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_COLOR = 2'd1;
	localparam logic [1:0] ST_COVER = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]  state_q;
	logic        out_valid_q;
	pix_out_t    out_q;
	work_t       job_q;
	logic [15:0] val_q [LANES];
	logic [28:0] fac_q [LANES];

	logic        out_free;
	logic        finish;
	logic [15:0] op_a  [LANES];
	logic [28:0] op_b  [LANES];
	logic [44:0] prod  [LANES];
	logic [44:0] rnd14 [LANES];
	logic [44:0] rnd28 [LANES];
	logic [44:0] rnd16 [LANES];
	logic [16:0] sum   [LANES];
	logic [15:0] res   [LANES];

	assign out_free = ~out_valid_q | ~out_stall;
	assign finish   = (state_q == ST_DONE) && out_free;
	assign pop      = ~empty && ((state_q == ST_IDLE) || finish);

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			case (state_q)
				ST_COLOR: begin
					op_a[l] = val_q[l];
					op_b[l] = job_q.incand ? 29'(TINT[l]) : fac_q[l];
				end
				ST_COVER: begin
					op_a[l] = val_q[l];
					op_b[l] = 29'(job_q.cover_scale);
				end
				default: begin
					// mix factor for the entry being popped
					op_a[l] = {1'b0, head.mix};
					op_b[l] = 29'(SLOPE[l]);
				end
			endcase
			prod[l]  = 45'(op_a[l]) * 45'(op_b[l]);
			rnd14[l] = (prod[l] + 45'(1 << 13)) >> 14;
			rnd28[l] = (prod[l] + 45'(1 << 27)) >> 28;
			rnd16[l] = (prod[l] + 45'(1 << 15)) >> 16;
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			sum[l] = 17'(val_q[l]) + 17'(job_q.base_offset);
			if (sum[l] < 17'(job_q.floor_lvl[l])) sum[l] = 17'(job_q.floor_lvl[l]);
			res[l] = sum[l][16] ? 16'hFFFF : sum[l][15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE:  if (pop) state_q <= ST_COLOR;
				ST_COLOR: state_q <= ST_COVER;
				ST_COVER: state_q <= ST_DONE;
				ST_DONE:  if (finish) state_q <= pop ? ST_COLOR : ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
			if (finish) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_q.red_out   <= res[LANE_R];
			out_q.green_out <= res[LANE_G];
			out_q.blue_out  <= res[LANE_B];
			out_q.position  <= job_q.position;
			out_q.frame_end <= job_q.frame_end;
			out_q.phase_out <= job_q.phase;
		end
		if (pop) job_q <= head;
		for (int l = 0; l < LANES; l++) begin
			if (pop) begin
				val_q[l] <= head.color[l];
				fac_q[l] <= 29'h1000_0000 - prod[l][28:0];
			end else if (state_q == ST_COLOR) begin
				if (job_q.incand) val_q[l] <= rnd14[l][15:0];
				else if (job_q.mix_on) val_q[l] <= rnd28[l][15:0];
			end else if (state_q == ST_COVER && job_q.cover_on) begin
				val_q[l] <= rnd16[l][15:0];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_color_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COLOR |-> $past(pop))
		else $error("color step entered without a popped entry");

	a_cover_follows_color: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COLOR |=> state_q == ST_COVER)
		else $error("cover step did not follow color step");

	a_finish_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> out_valid_q)
		else $error("finished pixel not presented at output");

endmodule
